>>> rtl/envg_pkg.sv
// Shared constants, register indexes and controller/datapath interface types for the envelope generator.
package envg_pkg;

  localparam int COUNT_BITS     = 16;
  localparam int LEVEL_BITS     = 16;
  localparam int ITER_BITS      = $clog2(LEVEL_BITS);
  localparam int TICK_BITS      = 16;
  localparam int OUT_LEVEL_BITS = 16;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam int IN_DATA_BITS   = 8;
  localparam int IN_USER_BITS   = 1;
  localparam int OUT_DATA_BITS  = 40;

  localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = {LEVEL_BITS{1'b1}};

  localparam logic [CFG_INDEX_BITS-1:0] REG_ENV_MODE     = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK_TICKS = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_TICKS  = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_POST_TICKS   = CFG_INDEX_BITS'(3);

  localparam logic       MODE_ASR = 1'b0;
  localparam logic       KIND_TRIGGER = 1'b1;

  typedef struct packed {
    logic step;
    logic prep;
    logic iterate;
    logic finish;
  } envg_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } envg_status_t;

endpackage

>>> rtl/envg_ctrl.sv
// Controller state machine that sequences item acceptance, the serial divider and result hand-off.
module envg_ctrl import envg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output envg_cmd_t    cmd,
  input  envg_status_t status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.step    = 1'b0;
    cmd.prep    = 1'b0;
    cmd.iterate = 1'b0;
    cmd.finish  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.step   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = status.need_div;
        state_next = status.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.iterate = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/envg_dp.sv
// Datapath: configuration registers, envelope counters, serial level divider and output register.
module envg_dp import envg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      item_kind,
  input  logic                      item_gate,
  input  envg_cmd_t                 cmd,
  output envg_status_t              status,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_DATA_BITS-1:0]  m_tdata
);

  logic                  env_mode;
  logic [TICK_BITS-1:0]  attack_ticks;
  logic [TICK_BITS-1:0]  decay_ticks;
  logic [TICK_BITS-1:0]  post_ticks;

  logic                  firing;
  logic [COUNT_BITS-1:0] attack_left, decay_left, post_left;
  logic [COUNT_BITS-1:0] attack_total, decay_total, post_total;
  logic [LEVEL_BITS-1:0] env_value, post_value;

  logic                  firing_next;
  logic [COUNT_BITS-1:0] attack_left_next, decay_left_next, post_left_next;
  logic [COUNT_BITS-1:0] attack_total_next, decay_total_next, post_total_next;
  logic [LEVEL_BITS-1:0] env_value_next, post_value_next;

  logic                  job_div, job_invert, job_post;
  logic [COUNT_BITS-1:0] job_n, job_d;
  logic                  do_attack, do_decay, do_tail;

  logic                  need_div, div_invert, div_to_post;
  logic [COUNT_BITS-1:0] div_n, div_d;
  logic [COUNT_BITS-1:0] rem;
  logic [LEVEL_BITS-1:0] low;
  logic [LEVEL_BITS-1:0] quo;
  logic [ITER_BITS-1:0]  iter;

  logic [COUNT_BITS+LEVEL_BITS-1:0] numer;
  logic [COUNT_BITS:0]              rem_sh;
  logic [COUNT_BITS:0]              rem_diff;
  logic                             rem_ge;
  logic [LEVEL_BITS-1:0]            quot_val;
  logic [LEVEL_BITS-1:0]            div_level;
  logic [LEVEL_BITS-1:0]            env_out, post_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      env_mode     <= 1'b0;
      attack_ticks <= TICK_BITS'(6);
      decay_ticks  <= TICK_BITS'(120);
      post_ticks   <= TICK_BITS'(0);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENV_MODE:     env_mode     <= cfg_data[0];
        REG_ATTACK_TICKS: attack_ticks <= TICK_BITS'(cfg_data);
        REG_DECAY_TICKS:  decay_ticks  <= TICK_BITS'(cfg_data);
        REG_POST_TICKS:   post_ticks   <= TICK_BITS'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    firing_next       = firing;
    attack_left_next  = attack_left;
    decay_left_next   = decay_left;
    post_left_next    = post_left;
    attack_total_next = attack_total;
    decay_total_next  = decay_total;
    post_total_next   = post_total;
    env_value_next    = env_value;
    post_value_next   = post_value;
    job_div           = 1'b0;
    job_invert        = 1'b0;
    job_post          = 1'b0;
    job_n             = '0;
    job_d             = '0;
    do_attack         = 1'b0;
    do_decay          = 1'b0;
    do_tail           = 1'b0;

    if (item_kind == KIND_TRIGGER) begin
      firing_next       = 1'b1;
      attack_left_next  = COUNT_BITS'(attack_ticks);
      decay_left_next   = COUNT_BITS'(decay_ticks);
      post_left_next    = COUNT_BITS'(post_ticks);
      attack_total_next = COUNT_BITS'(attack_ticks);
      decay_total_next  = COUNT_BITS'(decay_ticks);
      post_total_next   = COUNT_BITS'(post_ticks);
    end else if (env_mode == MODE_ASR) begin
      if (item_gate) begin
        post_value_next = '0;
        if (attack_left != '0) begin
          do_attack = 1'b1;
        end else begin
          env_value_next = FULL_LEVEL;
        end
      end else if (decay_left != '0) begin
        do_decay = 1'b1;
      end else begin
        do_tail = 1'b1;
      end
    end else if (firing) begin
      if (attack_left != '0) begin
        do_attack = 1'b1;
      end else if (decay_left != '0) begin
        do_decay = 1'b1;
      end else begin
        do_tail = 1'b1;
      end
    end

    if (do_attack) begin
      attack_left_next = attack_left - COUNT_BITS'(1);
      job_div          = 1'b1;
      job_invert       = 1'b1;
      job_n            = attack_left - COUNT_BITS'(1);
      job_d            = attack_total;
    end
    if (do_decay) begin
      if (post_left != '0) begin
        post_value_next = FULL_LEVEL;
      end
      decay_left_next = decay_left - COUNT_BITS'(1);
      job_div         = 1'b1;
      job_n           = decay_left - COUNT_BITS'(1);
      job_d           = decay_total;
    end
    if (do_tail) begin
      env_value_next = '0;
      if (post_left != '0) begin
        post_left_next = post_left - COUNT_BITS'(1);
        job_div        = 1'b1;
        job_post       = 1'b1;
        job_n          = post_left - COUNT_BITS'(1);
        job_d          = post_total;
      end else begin
        post_value_next = '0;
        firing_next     = 1'b0;
      end
    end
  end

  // The count is at most its total, so the quotient of n * FULL / d fits in LEVEL_BITS and the
  // upper half of the numerator starts below the divisor.
  assign numer    = {div_n, LEVEL_BITS'(0)} - {LEVEL_BITS'(0), div_n};
  assign rem_sh   = {rem, low[LEVEL_BITS-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_d});
  assign rem_diff = rem_sh - {1'b0, div_d};

  assign quot_val  = (div_d == '0) ? '0 : quo;
  assign div_level = div_invert ? (FULL_LEVEL - quot_val) : quot_val;
  assign env_out   = (need_div && !div_to_post) ? div_level : env_value;
  assign post_out  = (need_div && div_to_post) ? div_level : post_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      firing       <= 1'b0;
      attack_left  <= '0;
      decay_left   <= '0;
      post_left    <= '0;
      attack_total <= '0;
      decay_total  <= '0;
      post_total   <= '0;
      env_value    <= '0;
      post_value   <= '0;
      need_div     <= 1'b0;
    end else if (cmd.step) begin
      firing       <= firing_next;
      attack_left  <= attack_left_next;
      decay_left   <= decay_left_next;
      post_left    <= post_left_next;
      attack_total <= attack_total_next;
      decay_total  <= decay_total_next;
      post_total   <= post_total_next;
      env_value    <= env_value_next;
      post_value   <= post_value_next;
      need_div     <= job_div;
    end else if (cmd.finish) begin
      env_value <= env_out;
      post_value <= post_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      div_n       <= job_n;
      div_d       <= job_d;
      div_invert  <= job_invert;
      div_to_post <= job_post;
    end
    if (cmd.prep) begin
      rem  <= numer[COUNT_BITS+LEVEL_BITS-1:LEVEL_BITS];
      low  <= numer[LEVEL_BITS-1:0];
      quo  <= '0;
      iter <= '0;
    end else if (cmd.iterate) begin
      rem  <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      low  <= {low[LEVEL_BITS-2:0], 1'b0};
      quo  <= {quo[LEVEL_BITS-2:0], rem_ge};
      iter <= iter + ITER_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= OUT_DATA_BITS'({firing, OUT_LEVEL_BITS'(post_out), OUT_LEVEL_BITS'(env_out)});
    end
  end

  assign status.need_div = need_div;
  assign status.div_last = (iter == ITER_BITS'(LEVEL_BITS - 1));
  assign status.out_free = !m_tvalid || m_tready;

endmodule

>>> rtl/asr_ar_envelope_generator_top.sv
// Top level of the ASR/AR envelope generator: stream ports, configuration port and submodules.
// An item is taken in the idle state; its result is registered in the finish state, after the
// prepare state and, if its level needs a division, the divide state. The next item is taken once
// the controller is back in idle. The restoring divider yields one quotient bit per cycle.
// A result waits in the output register while the next item runs; an unaccepted one stalls it.
// Reset restores the register defaults and clears all envelope state and the output valid flag.
module asr_ar_envelope_generator_top import envg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_DATA_BITS-1:0]   s_tdata,   // [0] gate, rest zero.
  input  logic [IN_USER_BITS-1:0]   s_tuser,   // [0] kind.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_DATA_BITS-1:0]  m_tdata,   // [15:0] env_level, [31:16] post_level, [32] firing.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  envg_cmd_t    cmd;
  envg_status_t status;

  assign cfg_ready = 1'b1;

  envg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  envg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_kind (s_tuser[0]),
    .item_gate (s_tdata[0]),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> tb/sv/envg_tb_pkg.sv
// Scoreboard for the envelope generator: level prediction and result comparison.
package envg_tb_pkg;
  import envg_pkg::*;

  localparam logic KIND_TICK = ~KIND_TRIGGER;
  localparam logic MODE_AR = ~MODE_ASR;
  localparam int REG_COUNT = int'(REG_POST_TICKS) + 1;

  typedef struct packed {
    logic firing;
    logic [OUT_LEVEL_BITS-1:0] post_level;
    logic [OUT_LEVEL_BITS-1:0] env_level;
  } env_result_t;

  class envelope_scoreboard;
    logic mode;
    logic [TICK_BITS-1:0] attack_cfg, decay_cfg, post_cfg;
    logic firing;
    logic [COUNT_BITS-1:0] attack_left, decay_left, post_left;
    logic [COUNT_BITS-1:0] attack_total, decay_total, post_total;
    logic [LEVEL_BITS-1:0] env_level, post_level;
    env_result_t levels_due[$];
    int errors;

    function new();
      mode = MODE_ASR;
      attack_cfg = 6;
      decay_cfg = 120;
      post_cfg = 0;
      firing = 1'b0;
      attack_left = 0;
      decay_left = 0;
      post_left = 0;
      attack_total = 0;
      decay_total = 0;
      post_total = 0;
      env_level = 0;
      post_level = 0;
      errors = 0;
    endfunction

    function logic [LEVEL_BITS-1:0] fraction(logic [COUNT_BITS-1:0] n, logic [COUNT_BITS-1:0] d);
      if (d == 0) begin
        return '0;
      end
      return LEVEL_BITS'((64'(n) * 64'(FULL_LEVEL)) / 64'(d));
    endfunction

    function void note_config(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
      case (index)
        REG_ENV_MODE: begin
          mode = data[0];
        end
        REG_ATTACK_TICKS: begin
          attack_cfg = data[TICK_BITS-1:0];
        end
        REG_DECAY_TICKS: begin
          decay_cfg = data[TICK_BITS-1:0];
        end
        REG_POST_TICKS: begin
          post_cfg = data[TICK_BITS-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void rise_step();
      attack_left = attack_left - 1'b1;
      env_level = FULL_LEVEL - fraction(attack_left, attack_total);
    endfunction

    function void fall_step();
      if (post_left != 0) begin
        post_level = FULL_LEVEL;
      end
      decay_left = decay_left - 1'b1;
      env_level = fraction(decay_left, decay_total);
    endfunction

    function void tail_step();
      env_level = '0;
      if (post_left != 0) begin
        post_left = post_left - 1'b1;
        post_level = fraction(post_left, post_total);
      end else begin
        post_level = '0;
        firing = 1'b0;
      end
    endfunction

    function void note_item(logic kind, logic gate);
      env_result_t due;
      if (kind == KIND_TRIGGER) begin
        firing = 1'b1;
        attack_left = COUNT_BITS'(attack_cfg);
        decay_left = COUNT_BITS'(decay_cfg);
        post_left = COUNT_BITS'(post_cfg);
        attack_total = attack_left;
        decay_total = decay_left;
        post_total = post_left;
      end else if (mode == MODE_ASR) begin
        if (gate) begin
          post_level = '0;
          if (attack_left != 0) begin
            rise_step();
          end else begin
            env_level = FULL_LEVEL;
          end
        end else if (decay_left != 0) begin
          fall_step();
        end else begin
          tail_step();
        end
      end else if (firing) begin
        if (attack_left != 0) begin
          rise_step();
        end else if (decay_left != 0) begin
          fall_step();
        end else begin
          tail_step();
        end
      end
      due.firing = firing;
      due.post_level = OUT_LEVEL_BITS'(post_level);
      due.env_level = OUT_LEVEL_BITS'(env_level);
      levels_due.push_back(due);
    endfunction

    function void check_result(logic [OUT_DATA_BITS-1:0] data);
      env_result_t got, want;
      got = env_result_t'(data[$bits(env_result_t)-1:0]);
      if (levels_due.size() == 0) begin
        $error("result transfer with no item outstanding: %h", data);
        errors++;
        return;
      end
      want = levels_due.pop_front();
      if (got.env_level !== want.env_level) begin
        $error("env_level: expected %0d, got %0d", want.env_level, got.env_level);
        errors++;
      end
      if (got.post_level !== want.post_level) begin
        $error("post_level: expected %0d, got %0d", want.post_level, got.post_level);
        errors++;
      end
      if (got.firing !== want.firing) begin
        $error("firing: expected %0d, got %0d", want.firing, got.firing);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/testbench.sv
// Top-level testbench: drives items and register writes into the envelope generator and checks levels.
module testbench;
  import envg_pkg::*;
  import envg_tb_pkg::*;

  localparam int ITEM_TARGET = 1200;
  localparam int SETTLE_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEQ_CAP = 40;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata;
  logic [IN_USER_BITS-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  envelope_scoreboard sb;
  bit calm;
  int items_sent;
  int quiet_cycles;
  int stall_left;

  always #5 clk = ~clk;

  asr_ar_envelope_generator_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return '0;
    end
    if (r < 88) begin
      return CFG_DATA_BITS'($urandom_range(1, 8));
    end
    if (r < 95) begin
      return CFG_DATA_BITS'($urandom_range(9, 200));
    end
    if (r < 97) begin
      return '1;
    end
    return CFG_DATA_BITS'($urandom);
  endfunction

  function automatic int unsigned cap_len(int unsigned n);
    return (n > SEQ_CAP) ? SEQ_CAP : n;
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_item(s_tuser[0], s_tdata[0]);
      end
      if (cfg_valid && cfg_ready) begin
        sb.note_config(cfg_index, cfg_data);
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
      end
      if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic push_item(input logic kind, input logic gate);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = IN_USER_BITS'(kind);
    s_tdata = IN_DATA_BITS'(gate);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    while (sb.levels_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic retune();
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_ENV_MODE, CFG_DATA_BITS'($urandom));
      end else begin
        write_reg(REG_ENV_MODE, CFG_DATA_BITS'($urandom_range(0, 1)));
      end
    end
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_ATTACK_TICKS, pick_ticks());
    end
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_DECAY_TICKS, pick_ticks());
    end
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_POST_TICKS, pick_ticks());
    end
    if ($urandom_range(0, 9) == 0) begin
      write_reg(CFG_INDEX_BITS'($urandom_range(REG_COUNT, 255)), CFG_DATA_BITS'($urandom));
    end
  endtask

  task automatic play_asr_event();
    int unsigned hold, fall, k;
    hold = $urandom_range(0, cap_len(sb.attack_cfg) + 2);
    fall = cap_len(int'(sb.decay_cfg) + int'(sb.post_cfg)) + $urandom_range(1, 3);
    push_item(KIND_TRIGGER, 1'($urandom_range(0, 1)));
    for (k = 0; k < hold; k++) begin
      push_item(KIND_TICK, $urandom_range(0, 9) != 0);
    end
    for (k = 0; k < fall; k++) begin
      push_item(KIND_TICK, $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic play_ar_event();
    int unsigned span, k;
    span = cap_len(int'(sb.attack_cfg) + int'(sb.decay_cfg) + int'(sb.post_cfg))
           + $urandom_range(1, 3);
    push_item(KIND_TRIGGER, 1'($urandom_range(0, 1)));
    for (k = 0; k < span; k++) begin
      push_item(KIND_TICK, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic play_noise();
    int n, k;
    n = $urandom_range(3, 12);
    for (k = 0; k < n; k++) begin
      push_item(($urandom_range(0, 9) < 3) ? KIND_TRIGGER : KIND_TICK, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int n, k;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    items_sent = 0;
    quiet_cycles = 0;
    stall_left = 0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Ticks before any trigger, then a held attack, a release and a retrigger mid-decay.
    push_item(KIND_TICK, 1'b0);
    push_item(KIND_TICK, 1'b1);
    push_item(KIND_TRIGGER, 1'b0);
    repeat (3) push_item(KIND_TICK, 1'b1);
    repeat (2) push_item(KIND_TICK, 1'b0);
    push_item(KIND_TRIGGER, 1'b1);
    settle();

    // Short envelope whose decay runs with a post ramp pending, then the post ramp itself.
    write_reg(REG_ATTACK_TICKS, CFG_DATA_BITS'(1));
    write_reg(REG_DECAY_TICKS, CFG_DATA_BITS'(2));
    write_reg(REG_POST_TICKS, CFG_DATA_BITS'(3));
    push_item(KIND_TRIGGER, 1'b0);
    push_item(KIND_TICK, 1'b1);
    repeat (6) push_item(KIND_TICK, 1'b0);
    settle();

    // One-shot mode, widest attack and post lengths; the write past the register list must be ignored.
    write_reg(REG_ENV_MODE, '1);
    write_reg(REG_ATTACK_TICKS, '1);
    write_reg(REG_DECAY_TICKS, CFG_DATA_BITS'(1));
    write_reg(REG_POST_TICKS, '1);
    write_reg('1, '1);
    push_item(KIND_TICK, 1'b1);
    push_item(KIND_TRIGGER, 1'b1);
    push_item(KIND_TICK, 1'b0);
    push_item(KIND_TICK, 1'b1);
    settle();

    // Zero lengths: the first tick goes straight to the tail and clears firing.
    write_reg(REG_ATTACK_TICKS, '0);
    write_reg(REG_DECAY_TICKS, '0);
    write_reg(REG_POST_TICKS, '0);
    push_item(KIND_TRIGGER, 1'b0);
    repeat (2) push_item(KIND_TICK, 1'b0);
    settle();

    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      retune();
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) < 2) begin
          play_noise();
        end else if (sb.mode == MODE_ASR) begin
          play_asr_event();
        end else begin
          play_ar_event();
        end
      end
      settle();
    end

    if (sb.errors == 0 && sb.levels_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
